>>> hw/rtl/sbh_pkg.sv
// ----------------------------------------------------------------------------
// sbh_pkg
// Types and constants shared by the save block header token parser.
// ----------------------------------------------------------------------------
package sbh_pkg;

    localparam logic [1:0] RK_HEADER = 2'd0;
    localparam logic [1:0] RK_TOKEN  = 2'd1;
    localparam logic [1:0] RK_FINAL  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNC     = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
    localparam logic [2:0] ST_BAD_VER   = 3'd3;
    localparam logic [2:0] ST_BAD_COUNT = 3'd4;
    localparam logic [2:0] ST_NO_TERM   = 3'd5;

    localparam logic [1:0] BK_UNKNOWN = 2'd0;
    localparam logic [1:0] BK_LEVEL   = 2'd1;
    localparam logic [1:0] BK_GAME    = 2'd2;
    localparam logic [1:0] BK_CLIENT  = 2'd3;

    localparam logic [2:0] REG_LEVEL_MAGIC    = 3'd0;
    localparam logic [2:0] REG_GAME_MAGIC     = 3'd1;
    localparam logic [2:0] REG_GAME_VERSION   = 3'd2;
    localparam logic [2:0] REG_CLIENT_VERSION = 3'd3;
    localparam logic [2:0] REG_MAX_TOKENS     = 3'd4;
    localparam logic [2:0] REG_HEAP_LIMIT     = 3'd5;

    localparam logic [4:0] LEVEL_HDR_LEN = 5'd24;
    localparam logic [4:0] GAME_HDR_LEN  = 5'd20;
    localparam logic [4:0] MIN_LEN       = 5'd8;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] block_size;
        logic        first_byte;
    } in_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [2:0]  status_code;
        logic [1:0]  block_kind;
        logic [30:0] data_bytes;
        logic [30:0] table_entries;
        logic [30:0] tokens_declared;
        logic [30:0] token_table_bytes;
        logic [30:0] token_number;
        logic [30:0] token_start;
        logic [30:0] token_length;
        logic [31:0] payload_start;
        logic        last_result;
    } out_t;

    typedef struct packed {
        logic [1:0] n;
        out_t       r0;
        out_t       r1;
    } push_t;

endpackage

>>> hw/rtl/sbh_front.sv
// ----------------------------------------------------------------------------
// sbh_front
// Byte parser: assembles and checks the header, scans tokens, and forms up
// to two result items per input byte.
// ----------------------------------------------------------------------------
module sbh_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              take,
    input  sbh_pkg::in_t      item,
    output sbh_pkg::push_t    push
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_TOKENS = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    logic [31:0] level_magic_reg, game_magic_reg, game_version_reg, client_version_reg;
    logic [30:0] max_tokens_reg, heap_limit_reg;

    logic [1:0]  phase_reg, phase_next;
    logic [4:0]  bc_reg, bc_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] magic_reg, magic_next;
    logic [31:0] w_reg [4];
    logic [31:0] w_next [4];
    logic [30:0] tc_reg, tc_next;
    logic [30:0] off_reg, off_next;
    logic [30:0] cs_reg, cs_next;
    logic [1:0]  kind_reg, kind_next;
    logic        hv_reg, hv_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_magic_reg    <= '0;
            game_magic_reg     <= '0;
            game_version_reg   <= '0;
            client_version_reg <= '0;
            max_tokens_reg     <= '0;
            heap_limit_reg     <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                sbh_pkg::REG_LEVEL_MAGIC:    level_magic_reg    <= cfg_data;
                sbh_pkg::REG_GAME_MAGIC:     game_magic_reg     <= cfg_data;
                sbh_pkg::REG_GAME_VERSION:   game_version_reg   <= cfg_data;
                sbh_pkg::REG_CLIENT_VERSION: client_version_reg <= cfg_data;
                sbh_pkg::REG_MAX_TOKENS:     max_tokens_reg     <= cfg_data[30:0];
                sbh_pkg::REG_HEAP_LIMIT:     heap_limit_reg     <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            bc_reg    <= '0;
            size_reg  <= '0;
            shift_reg <= '0;
            magic_reg <= '0;
            w_reg     <= '{default: '0};
            tc_reg    <= '0;
            off_reg   <= '0;
            cs_reg    <= '0;
            kind_reg  <= sbh_pkg::BK_UNKNOWN;
            hv_reg    <= 1'b0;
        end else if (take) begin
            phase_reg <= phase_next;
            bc_reg    <= bc_next;
            size_reg  <= size_next;
            shift_reg <= shift_next;
            magic_reg <= magic_next;
            w_reg     <= w_next;
            tc_reg    <= tc_next;
            off_reg   <= off_next;
            cs_reg    <= cs_next;
            kind_reg  <= kind_next;
            hv_reg    <= hv_next;
        end
    end

    logic [1:0]  ph;
    logic [4:0]  hlen;
    logic [31:0] d, t, c, s;
    logic [32:0] pend;
    logic [31:0] off1;
    logic [30:0] tc1;
    logic        bad;
    logic [1:0]  n;
    logic [1:0]  rk0, rk1;
    logic [2:0]  st0, st1;
    logic [30:0] tn0, ts0, tl0, tn1, ts1;
    logic [31:0] ps0, ps1;
    logic        l0;

    always_comb begin
        ph         = phase_reg;
        bc_next    = bc_reg;
        size_next  = size_reg;
        shift_next = shift_reg;
        magic_next = magic_reg;
        w_next     = w_reg;
        tc_next    = tc_reg;
        off_next   = off_reg;
        cs_next    = cs_reg;
        kind_next  = kind_reg;
        hv_next    = hv_reg;
        n = 2'd0;
        rk0 = sbh_pkg::RK_FINAL; st0 = sbh_pkg::ST_OK;
        tn0 = '0; ts0 = '0; tl0 = '0; ps0 = '0; l0 = 1'b1;
        rk1 = sbh_pkg::RK_FINAL; st1 = sbh_pkg::ST_OK;
        tn1 = '0; ts1 = '0; ps1 = '0;
        hlen = sbh_pkg::GAME_HDR_LEN;
        d = '0; t = '0; c = '0; s = '0; pend = '0; off1 = '0; tc1 = '0; bad = 1'b0;

        if (item.first_byte) begin
            size_next  = item.block_size;
            bc_next    = '0;
            shift_next = '0;
            magic_next = '0;
            w_next     = '{default: '0};
            tc_next    = '0;
            off_next   = '0;
            cs_next    = '0;
            kind_next  = sbh_pkg::BK_UNKNOWN;
            hv_next    = 1'b0;
            ph         = PH_HEADER;
            if (item.block_size < 32'(sbh_pkg::MIN_LEN)) begin
                ph = PH_DONE;
                n  = 2'd1;
                st0 = sbh_pkg::ST_TRUNC;
            end
        end
        phase_next = ph;

        if (n == 2'd0 && ph == PH_HEADER) begin
            shift_next = {item.data_byte, shift_next[31:8]};
            bc_next    = bc_next + 5'd1;
            if (bc_next[1:0] == 2'b00) begin
                if (bc_next == 5'd4) begin
                    magic_next = shift_next;
                end else if (bc_next == 5'd8) begin
                    if (magic_next == level_magic_reg) begin
                        if (shift_next != game_version_reg) begin
                            n = 2'd1; st0 = sbh_pkg::ST_BAD_VER;
                        end else begin
                            kind_next = sbh_pkg::BK_LEVEL;
                        end
                    end else if (magic_next == game_magic_reg) begin
                        if (shift_next == client_version_reg) begin
                            kind_next = sbh_pkg::BK_CLIENT;
                        end else if (shift_next == game_version_reg) begin
                            kind_next = sbh_pkg::BK_GAME;
                        end else begin
                            n = 2'd1; st0 = sbh_pkg::ST_BAD_VER;
                        end
                    end else begin
                        n = 2'd1; st0 = sbh_pkg::ST_BAD_MAGIC;
                    end
                    hlen = (kind_next == sbh_pkg::BK_LEVEL) ? sbh_pkg::LEVEL_HDR_LEN
                                                            : sbh_pkg::GAME_HDR_LEN;
                    if (n == 2'd0 && size_next < 32'(hlen)) begin
                        n = 2'd1; st0 = sbh_pkg::ST_TRUNC;
                    end
                    if (n != 2'd0) begin
                        phase_next = PH_DONE;
                    end
                end else begin
                    w_next[2'(bc_next[4:2] - 3'd3)] = shift_next;
                    hlen = (kind_next == sbh_pkg::BK_LEVEL) ? sbh_pkg::LEVEL_HDR_LEN
                                                            : sbh_pkg::GAME_HDR_LEN;
                    if (bc_next >= hlen) begin
                        d = w_next[0];
                        if (kind_next == sbh_pkg::BK_LEVEL) begin
                            t = w_next[1]; c = w_next[2]; s = w_next[3];
                        end else begin
                            t = '0; c = w_next[1]; s = w_next[2];
                        end
                        bad = d[31] | t[31] | c[31] | s[31]
                            | (c[30:0] > max_tokens_reg)
                            | (s[30:0] > heap_limit_reg)
                            | (d[30:0] > heap_limit_reg);
                        pend = 33'(hlen) + {1'b0, s} + {1'b0, d};
                        phase_next = PH_DONE;
                        if (bad) begin
                            n = 2'd1; st0 = sbh_pkg::ST_BAD_COUNT;
                        end else if (pend > {1'b0, size_next}) begin
                            n = 2'd1; st0 = sbh_pkg::ST_TRUNC;
                        end else begin
                            hv_next = 1'b1;
                            n   = 2'd1;
                            rk0 = sbh_pkg::RK_HEADER;
                            ps0 = 32'(hlen) + s;
                            l0  = 1'b0;
                            if (c == '0) begin
                                n = 2'd2; ps1 = 32'(hlen);
                            end else if (s == '0) begin
                                n = 2'd2; st1 = sbh_pkg::ST_NO_TERM;
                            end else begin
                                phase_next = PH_TOKENS;
                            end
                        end
                    end
                end
            end
        end else if (ph == PH_TOKENS) begin
            hlen = (kind_reg == sbh_pkg::BK_LEVEL) ? sbh_pkg::LEVEL_HDR_LEN
                                                   : sbh_pkg::GAME_HDR_LEN;
            if (kind_reg == sbh_pkg::BK_LEVEL) begin
                c = w_reg[2]; s = w_reg[3];
            end else begin
                c = w_reg[1]; s = w_reg[2];
            end
            off1 = {1'b0, off_reg} + 32'd1;
            tc1  = tc_reg + 31'd1;
            off_next = off1[30:0];
            if (item.data_byte == 8'd0) begin
                n   = 2'd1;
                rk0 = sbh_pkg::RK_TOKEN;
                tn0 = tc_reg;
                ts0 = cs_reg;
                tl0 = off_reg - cs_reg;
                l0  = 1'b0;
                tc_next = tc1;
                cs_next = off1[30:0];
                if (tc1 == c[30:0]) begin
                    phase_next = PH_DONE;
                    n   = 2'd2;
                    tn1 = tc1;
                    ts1 = off1[30:0];
                    ps1 = 32'(hlen) + off1;
                end
            end
            if (!(item.data_byte == 8'd0 && tc1 == c[30:0]) && off1 >= s) begin
                phase_next = PH_DONE;
                if (n == 2'd0) begin
                    n = 2'd1; st0 = sbh_pkg::ST_NO_TERM; tn0 = tc_next;
                end else begin
                    n = 2'd2; st1 = sbh_pkg::ST_NO_TERM; tn1 = tc_next;
                end
            end
        end
    end

    logic [30:0] f_data, f_table, f_tokc, f_toks;

    always_comb begin
        f_data  = hv_next ? w_next[0][30:0] : '0;
        f_table = '0;
        f_tokc  = '0;
        f_toks  = '0;
        if (hv_next) begin
            if (kind_next == sbh_pkg::BK_LEVEL) begin
                f_table = w_next[1][30:0];
                f_tokc  = w_next[2][30:0];
                f_toks  = w_next[3][30:0];
            end else begin
                f_tokc  = w_next[1][30:0];
                f_toks  = w_next[2][30:0];
            end
        end
        push.n = n;
        push.r0.result_kind       = rk0;
        push.r0.status_code       = st0;
        push.r0.block_kind        = hv_next ? kind_next : sbh_pkg::BK_UNKNOWN;
        push.r0.data_bytes        = f_data;
        push.r0.table_entries     = f_table;
        push.r0.tokens_declared   = f_tokc;
        push.r0.token_table_bytes = f_toks;
        push.r0.token_number      = tn0;
        push.r0.token_start       = ts0;
        push.r0.token_length      = tl0;
        push.r0.payload_start     = ps0;
        push.r0.last_result       = l0;
        push.r1.result_kind       = rk1;
        push.r1.status_code       = st1;
        push.r1.block_kind        = hv_next ? kind_next : sbh_pkg::BK_UNKNOWN;
        push.r1.data_bytes        = f_data;
        push.r1.table_entries     = f_table;
        push.r1.tokens_declared   = f_tokc;
        push.r1.token_table_bytes = f_toks;
        push.r1.token_number      = tn1;
        push.r1.token_start       = ts1;
        push.r1.token_length      = '0;
        push.r1.payload_start     = ps1;
        push.r1.last_result       = 1'b1;
    end

endmodule

>>> hw/rtl/sbh_queue.sv
// ----------------------------------------------------------------------------
// sbh_queue
// Four-entry result queue: takes up to two items a cycle, gives one.
// ----------------------------------------------------------------------------
module sbh_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_en,
    input  sbh_pkg::push_t push,
    output logic           space,
    output logic           m_valid,
    input  logic           m_ready,
    output sbh_pkg::out_t  m_item
);

    sbh_pkg::out_t mem [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] nw;
    logic       pop;

    assign nw      = wr_en ? push.n : 2'd0;
    assign m_valid = cnt_reg != 3'd0;
    assign pop     = m_valid && m_ready;
    assign space   = cnt_reg <= 3'd2;
    assign m_item  = mem[rp_reg];
    assign cnt_next = cnt_reg + 3'(nw) - 3'(pop);

    always_ff @(posedge aclk) begin
        if (nw != 2'd0) begin
            mem[wp_reg] <= push.r0;
        end
        if (nw == 2'd2) begin
            mem[wp_reg + 2'd1] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_reg + nw;
            rp_reg  <= rp_reg + 2'(pop);
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> hw/rtl/save_block_header_token_parser_core.sv
// ----------------------------------------------------------------------------
// save_block_header_token_parser_core
// Saved-state block parser: header check and token table scan.
//
// Input channel s_*: one block byte per item, first_byte marks a new block
// and carries the block size. Result channel m_*: header report, one item
// per NUL-terminated token, and a final status item (last_result set).
// Configuration channel cfg_*: register writes, always ready. Writes are to be
// taken while the block is idle; the user must ensure this, the block does not.
// Throughput: one byte per cycle while s_ready is high; a byte gives up to
// two results, which leave at one per cycle while m_ready is high, through a
// four-entry queue. s_ready is high while at least two queue entries are free.
// Each result is registered into the queue as its byte is accepted.
// Reset clears the parse state and all registers; bytes before the first
// first_byte are ignored. When m_ready stays low the queue fills and s_ready
// drops; nothing is lost.
// ----------------------------------------------------------------------------
module save_block_header_token_parser_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  sbh_pkg::in_t   s_item,
    output logic           m_valid,
    input  logic           m_ready,
    output sbh_pkg::out_t  m_item,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [31:0]    cfg_data
);

    sbh_pkg::push_t push;
    logic           take;
    logic           space;

    assign cfg_ready = 1'b1;
    assign s_ready   = space;
    assign take      = s_valid && space;

    sbh_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .item      (s_item),
        .push      (push)
    );

    sbh_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (take),
        .push    (push),
        .space   (space),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

>>> tb/save_block_header_token_parser_core_test.sv
// ----------------------------------------------------------------------------
// save_block_header_token_parser_core_test
// Self-checking bench for the save block header token parser.
//
// Blocks are built with random headers, token tables and payloads and sent
// byte by byte; a local model predicts header, token and final items, which
// are checked field by field against the result channel. Both channels idle
// at random, and several register settings are used, extremes included.
// ----------------------------------------------------------------------------
module save_block_header_token_parser_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {PH_IDLE, PH_HEADER, PH_TOKENS, PH_DONE} phase_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    sbh_pkg::in_t  s_item = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    sbh_pkg::out_t m_item;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [2:0]    cfg_index = '0;
    logic [31:0]   cfg_data = '0;

    save_block_header_token_parser_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    // model registers and parse state
    logic [31:0] level_magic_q, game_magic_q, game_version_q, client_version_q;
    logic [31:0] max_tokens_q, heap_limit_q;
    phase_t      phase_q;
    logic [31:0] byte_cnt, size_q, shift_q, magic_q, version_q;
    logic [31:0] hdr_word [4];
    logic [30:0] tok_cnt, tab_off, tok_begin;
    logic [1:0]  kind_q;
    logic        hdr_ok;

    sbh_pkg::out_t expected_items [$];
    int            errors = 0;
    int            bytes_sent = 0;
    int            stall_left = 0;
    bit            quiet = 1'b0;

    function automatic logic [31:0] hdr_len();
        return (kind_q == sbh_pkg::BK_LEVEL) ? 32'(sbh_pkg::LEVEL_HDR_LEN)
                                             : 32'(sbh_pkg::GAME_HDR_LEN);
    endfunction
    function automatic logic [31:0] f_table();
        return (kind_q == sbh_pkg::BK_LEVEL) ? hdr_word[1] : 32'd0;
    endfunction
    function automatic logic [31:0] f_tokc();
        return (kind_q == sbh_pkg::BK_LEVEL) ? hdr_word[2] : hdr_word[1];
    endfunction
    function automatic logic [31:0] f_toks();
        return (kind_q == sbh_pkg::BK_LEVEL) ? hdr_word[3] : hdr_word[2];
    endfunction

    task automatic push_result(input logic [1:0] rk, input logic [2:0] st,
                               input logic [30:0] tnum, input logic [30:0] tstart,
                               input logic [30:0] tlen, input logic [31:0] pstart,
                               input logic last);
        sbh_pkg::out_t r;
        r = '0;
        r.result_kind   = rk;
        r.status_code   = st;
        r.token_number  = tnum;
        r.token_start   = tstart;
        r.token_length  = tlen;
        r.payload_start = pstart;
        r.last_result   = last;
        if (hdr_ok) begin
            r.block_kind        = kind_q;
            r.data_bytes        = hdr_word[0][30:0];
            r.table_entries     = f_table()[30:0];
            r.tokens_declared   = f_tokc()[30:0];
            r.token_table_bytes = f_toks()[30:0];
        end
        expected_items.insert(expected_items.size(), r);
    endtask

    task automatic block_error(input logic [2:0] st);
        hdr_ok  = 1'b0;
        phase_q = PH_DONE;
        push_result(sbh_pkg::RK_FINAL, st, '0, '0, '0, '0, 1'b1);
    endtask

    task automatic header_byte(input logic [7:0] b);
        logic [31:0] d, t, c, s;
        logic [32:0] pend;
        shift_q  = {b, shift_q[31:8]};
        byte_cnt = byte_cnt + 32'd1;
        if (byte_cnt[1:0] != 2'd0) return;
        if (byte_cnt == 32'd4) begin
            magic_q = shift_q;
            return;
        end
        if (byte_cnt == 32'd8) begin
            version_q = shift_q;
            if (magic_q == level_magic_q) begin
                if (version_q != game_version_q) begin
                    block_error(sbh_pkg::ST_BAD_VER);
                    return;
                end
                kind_q = sbh_pkg::BK_LEVEL;
            end else if (magic_q == game_magic_q) begin
                if (version_q == client_version_q) kind_q = sbh_pkg::BK_CLIENT;
                else if (version_q == game_version_q) kind_q = sbh_pkg::BK_GAME;
                else begin
                    block_error(sbh_pkg::ST_BAD_VER);
                    return;
                end
            end else begin
                block_error(sbh_pkg::ST_BAD_MAGIC);
                return;
            end
            if (size_q < hdr_len()) block_error(sbh_pkg::ST_TRUNC);
            return;
        end
        hdr_word[2'((byte_cnt - 32'd12) >> 2)] = shift_q;
        if (byte_cnt < hdr_len()) return;
        d = hdr_word[0];
        t = f_table();
        c = f_tokc();
        s = f_toks();
        if (d[31] || t[31] || c[31] || c > max_tokens_q || s[31] || s > heap_limit_q
                || d > heap_limit_q) begin
            block_error(sbh_pkg::ST_BAD_COUNT);
            return;
        end
        pend = 33'(hdr_len()) + 33'(s) + 33'(d);
        if (pend > 33'(size_q)) begin
            block_error(sbh_pkg::ST_TRUNC);
            return;
        end
        hdr_ok = 1'b1;
        push_result(sbh_pkg::RK_HEADER, sbh_pkg::ST_OK, '0, '0, '0, hdr_len() + s, 1'b0);
        tok_cnt   = '0;
        tab_off   = '0;
        tok_begin = '0;
        if (c == 32'd0) begin
            phase_q = PH_DONE;
            push_result(sbh_pkg::RK_FINAL, sbh_pkg::ST_OK, '0, '0, '0, hdr_len(), 1'b1);
        end else if (s == 32'd0) begin
            phase_q = PH_DONE;
            push_result(sbh_pkg::RK_FINAL, sbh_pkg::ST_NO_TERM, '0, '0, '0, '0, 1'b1);
        end else begin
            phase_q = PH_TOKENS;
        end
    endtask

    task automatic token_byte(input logic [7:0] b);
        logic [30:0] off;
        off = tab_off;
        if (b == 8'd0) begin
            push_result(sbh_pkg::RK_TOKEN, sbh_pkg::ST_OK, tok_cnt, tok_begin,
                        off - tok_begin, '0, 1'b0);
            tok_cnt   = tok_cnt + 31'd1;
            tok_begin = off + 31'd1;
            if ({1'b0, tok_cnt} == f_tokc()) begin
                phase_q = PH_DONE;
                push_result(sbh_pkg::RK_FINAL, sbh_pkg::ST_OK, tok_cnt, off + 31'd1, '0,
                            hdr_len() + {1'b0, off} + 32'd1, 1'b1);
                tab_off = off + 31'd1;
                return;
            end
        end
        tab_off = off + 31'd1;
        if ({1'b0, off} + 32'd1 >= f_toks()) begin
            phase_q = PH_DONE;
            push_result(sbh_pkg::RK_FINAL, sbh_pkg::ST_NO_TERM, tok_cnt, '0, '0, '0, 1'b1);
        end
    endtask

    task automatic model_step(input sbh_pkg::in_t it);
        if (it.first_byte) begin
            size_q    = it.block_size;
            byte_cnt  = '0;
            shift_q   = '0;
            magic_q   = '0;
            version_q = '0;
            hdr_word  = '{default: '0};
            tok_cnt   = '0;
            tab_off   = '0;
            tok_begin = '0;
            kind_q    = sbh_pkg::BK_UNKNOWN;
            hdr_ok    = 1'b0;
            phase_q   = PH_HEADER;
            if (size_q < 32'(sbh_pkg::MIN_LEN)) begin
                block_error(sbh_pkg::ST_TRUNC);
                return;
            end
        end
        if (phase_q == PH_HEADER) header_byte(it.data_byte);
        else if (phase_q == PH_TOKENS) token_byte(it.data_byte);
    endtask

    // result checking and receiver stalls
    task automatic check_field(input string nm, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            $error("%s expected %0h actual %0h", nm, e, a);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        sbh_pkg::out_t e;
        if (aresetn && m_valid && m_ready) begin
            stall_left = quiet ? 0 : $urandom_range(0, 14);
            if (expected_items.size() == 0) begin
                $error("unexpected result item, kind %0d", m_item.result_kind);
                errors++;
            end else begin
                e = expected_items.pop_front();
                check_field("result_kind", 32'(e.result_kind), 32'(m_item.result_kind));
                check_field("status_code", 32'(e.status_code), 32'(m_item.status_code));
                check_field("block_kind", 32'(e.block_kind), 32'(m_item.block_kind));
                check_field("data_bytes", 32'(e.data_bytes), 32'(m_item.data_bytes));
                check_field("table_entries", 32'(e.table_entries),
                            32'(m_item.table_entries));
                check_field("tokens_declared", 32'(e.tokens_declared),
                            32'(m_item.tokens_declared));
                check_field("token_table_bytes", 32'(e.token_table_bytes),
                            32'(m_item.token_table_bytes));
                check_field("token_number", 32'(e.token_number), 32'(m_item.token_number));
                check_field("token_start", 32'(e.token_start), 32'(m_item.token_start));
                check_field("token_length", 32'(e.token_length), 32'(m_item.token_length));
                check_field("payload_start", e.payload_start, m_item.payload_start);
                check_field("last_result", 32'(e.last_result), 32'(m_item.last_result));
            end
        end
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // stimulus helpers; every task is entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic [31:0] size, input logic fb);
        int gap;
        sbh_pkg::in_t it;
        gap = quiet ? 0 : $urandom_range(0, 14);
        it.data_byte  = b;
        it.block_size = size;
        it.first_byte = fb;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        model_step(it);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_items.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            sbh_pkg::REG_LEVEL_MAGIC:    level_magic_q    = val;
            sbh_pkg::REG_GAME_MAGIC:     game_magic_q     = val;
            sbh_pkg::REG_GAME_VERSION:   game_version_q   = val;
            sbh_pkg::REG_CLIENT_VERSION: client_version_q = val;
            sbh_pkg::REG_MAX_TOKENS:     max_tokens_q     = {1'b0, val[30:0]};
            sbh_pkg::REG_HEAP_LIMIT:     heap_limit_q     = {1'b0, val[30:0]};
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic configure(input logic [31:0] lm, input logic [31:0] gm,
                             input logic [31:0] gv, input logic [31:0] cv,
                             input logic [31:0] mt, input logic [31:0] hl);
        write_reg(sbh_pkg::REG_LEVEL_MAGIC, lm);
        write_reg(sbh_pkg::REG_GAME_MAGIC, gm);
        write_reg(sbh_pkg::REG_GAME_VERSION, gv);
        write_reg(sbh_pkg::REG_CLIENT_VERSION, cv);
        write_reg(sbh_pkg::REG_MAX_TOKENS, mt);
        write_reg(sbh_pkg::REG_HEAP_LIMIT, hl);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_bytes(input logic [7:0] q [$], input logic [31:0] size, input int n);
        for (int i = 0; i < n && i < q.size(); i++)
            send_byte(q[i], (i == 0) ? size : $urandom, i == 0);
    endtask

    function automatic void put_word(ref logic [7:0] q [$], input logic [31:0] w);
        for (int i = 0; i < 4; i++) q.insert(q.size(), w[8*i +: 8]);
    endfunction

    // one block with random content, mostly well formed
    task automatic random_block();
        logic [7:0]  q [$];
        logic [7:0]  tab [$];
        logic [31:0] magic, ver, d, t, c, s, hl, size;
        int mode, ntok, n, len;
        quiet = ($urandom_range(0, 4) == 0);
        mode  = $urandom_range(0, 9);
        if (mode < 4)      magic = level_magic_q;
        else if (mode < 9) magic = game_magic_q;
        else               magic = $urandom;
        if (mode > 6 && mode < 9) ver = client_version_q;
        else                      ver = game_version_q;
        if ($urandom_range(0, 9) == 0) ver = $urandom;
        hl = (magic == level_magic_q) ? 32'(sbh_pkg::LEVEL_HDR_LEN)
                                      : 32'(sbh_pkg::GAME_HDR_LEN);
        ntok = $urandom_range(0, 5);
        for (int i = 0; i < ntok; i++) begin
            len = $urandom_range(0, 5);
            repeat (len) tab.insert(tab.size(), 8'($urandom_range(1, 255)));
            tab.insert(tab.size(), 8'd0);
        end
        if (ntok > 0 && $urandom_range(0, 9) == 0) tab.pop_back();
        repeat ($urandom_range(0, 2)) tab.insert(tab.size(), 8'($urandom_range(0, 255)));
        s = tab.size();
        c = ntok;
        case ($urandom_range(0, 19))
            0: c = ntok + 1;
            1: c = 0;
            2: c = max_tokens_q + 1;
            3: c = $urandom | 32'h8000_0000;
            default: ;
        endcase
        d = $urandom_range(0, 8);
        if ($urandom_range(0, 19) == 0) d = heap_limit_q + 1;
        if ($urandom_range(0, 29) == 0) s = heap_limit_q + 1;
        t = $urandom_range(0, 3);
        if ($urandom_range(0, 29) == 0) t = $urandom | 32'h8000_0000;
        put_word(q, magic);
        put_word(q, ver);
        put_word(q, d);
        if (hl == 32'(sbh_pkg::LEVEL_HDR_LEN)) put_word(q, t);
        put_word(q, c);
        put_word(q, s);
        foreach (tab[i]) q.insert(q.size(), tab[i]);
        repeat ($urandom_range(0, 4)) q.insert(q.size(), 8'($urandom_range(0, 255)));
        size = hl + s + d;
        case ($urandom_range(0, 19))
            0: size = $urandom_range(0, 7);
            1: size = $urandom_range(8, hl - 1);
            2: size = size - 1;
            3: size = size + $urandom_range(1, 1000);
            4: size = $urandom;
            default: ;
        endcase
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, q.size()) : q.size();
        send_bytes(q, size, n);
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), $urandom, 1'b0);
    endtask

    // tests
    task automatic test_reset_registers();
        logic [7:0] q [$];
        send_byte(8'hff, 32'hffff_ffff, 1'b0);
        send_byte(8'h00, 32'h0000_0000, 1'b0);
        repeat (24) q.insert(q.size(), 8'd0);
        send_bytes(q, 32'd24, 24);
        wait_idle();
    endtask

    task automatic test_directed();
        logic [7:0] q [$];
        configure(32'h0041_5641, 32'h0045_5641, 32'd71, 32'd65, 32'd8, 32'd64);
        send_byte(8'h41, 32'd7, 1'b1);
        put_word(q, 32'h1234_5678);
        put_word(q, 32'd71);
        send_bytes(q, 32'd100, 8);
        q = {};
        put_word(q, 32'h0041_5641);
        put_word(q, 32'd70);
        send_bytes(q, 32'd100, 8);
        q = {};
        put_word(q, 32'h0041_5641);
        put_word(q, 32'd71);
        send_bytes(q, 32'd23, 8);
        q = {};
        put_word(q, 32'h0045_5641);
        put_word(q, 32'd65);
        send_bytes(q, 32'd19, 8);
        wait_idle();
    endtask

    task automatic test_random_phase(input int nbytes);
        int target;
        target = bytes_sent + nbytes;
        while (bytes_sent < target) random_block();
        wait_idle();
    endtask

    task automatic test_random();
        configure(32'h0041_5641, 32'h0045_5641, 32'd71, 32'd65, 32'd8, 32'd64);
        test_random_phase(400);
        configure(32'hffff_ffff, 32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h7fff_ffff);
        test_random_phase(300);
        configure(32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                  32'd0, 32'd0);
        test_random_phase(150);
        configure($urandom, $urandom, $urandom, $urandom, 32'd3, 32'd10);
        test_random_phase(300);
        configure($urandom, $urandom, 32'd5, 32'd5, 32'hffff_ffff, 32'hffff_ffff);
        test_random_phase(300);
        configure($urandom, $urandom, $urandom, $urandom,
                  $urandom_range(1, 6), $urandom_range(8, 40));
        test_random_phase(400);
    endtask

    initial begin
        level_magic_q = '0; game_magic_q = '0; game_version_q = '0;
        client_version_q = '0; max_tokens_q = '0; heap_limit_q = '0;
        phase_q = PH_IDLE; byte_cnt = '0; size_q = '0; shift_q = '0;
        magic_q = '0; version_q = '0; hdr_word = '{default: '0};
        tok_cnt = '0; tab_off = '0; tok_begin = '0; kind_q = sbh_pkg::BK_UNKNOWN;
        hdr_ok = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_registers();
        test_directed();
        test_random();
        repeat (20) @(negedge aclk);
        if (errors == 0 && expected_items.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
